// ----- src/prxyz_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// prxyz_pkg
// Shared types, widths and saturation helpers for the 3D point rotator.
// ----------------------------------------------------------------------------
package prxyz_pkg;

	// field formats
	localparam int COORD_W        = 32;  // Q16.16 coordinates
	localparam int TRIG_W         = 16;  // Q2.14 sine / cosine
	localparam int COORD_FRAC_BITS = 16;
	localparam int TRIG_FRAC_BITS = 14;

	// internal widths
	localparam int STAGE_W  = 40;                // coordinate between rotations
	localparam int PROD_W   = STAGE_W + TRIG_W;  // one product
	localparam int SUM_W    = PROD_W + 2;        // sum of two products plus rounding
	localparam int CFG_IDX_W = 3;

	// center z, fixed at build time
	localparam logic signed [COORD_W-1:0] PIVOT_Z = 32'sd0;

	localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
	localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};
	localparam logic signed [STAGE_W-1:0] STAGE_MAX = {1'b0, {(STAGE_W-1){1'b1}}};
	localparam logic signed [STAGE_W-1:0] STAGE_MIN = {1'b1, {(STAGE_W-1){1'b0}}};

	// round half up before the floor shift
	localparam logic signed [SUM_W-1:0] RND_HALF = SUM_W'(64'd1 << (TRIG_FRAC_BITS - 1));

	// register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_COS_A   = 3'd0,
		REG_SIN_A   = 3'd1,
		REG_COS_B   = 3'd2,
		REG_SIN_B   = 3'd3,
		REG_COS_G   = 3'd4,
		REG_SIN_G   = 3'd5,
		REG_PIVOT_X = 3'd6,
		REG_PIVOT_Y = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic signed [TRIG_W-1:0]  cos_a;
		logic signed [TRIG_W-1:0]  sin_a;
		logic signed [TRIG_W-1:0]  cos_b;
		logic signed [TRIG_W-1:0]  sin_b;
		logic signed [TRIG_W-1:0]  cos_g;
		logic signed [TRIG_W-1:0]  sin_g;
		logic signed [COORD_W-1:0] pivot_x;
		logic signed [COORD_W-1:0] pivot_y;
	} cfg_t;

	typedef struct packed {
		logic                      clip;
		logic signed [STAGE_W-1:0] val;
	} sat_stage_t;

	typedef struct packed {
		logic                      clip;
		logic signed [COORD_W-1:0] val;
	} sat_coord_t;

	// saturate a shifted sum to the stage range
	function automatic sat_stage_t sat_stage(input logic signed [SUM_W-1:0] v);
		sat_stage_t r;
		logic [SUM_W-STAGE_W:0] top;
		top = v[SUM_W-1:STAGE_W-1];
		if ((&top) || !(|top)) begin
			r.clip = 1'b0;
			r.val  = v[STAGE_W-1:0];
		end else begin
			r.clip = 1'b1;
			r.val  = v[SUM_W-1] ? STAGE_MIN : STAGE_MAX;
		end
		return r;
	endfunction

	// saturate a recentered coordinate to 32 bits
	function automatic sat_coord_t sat_coord(input logic signed [STAGE_W:0] v);
		sat_coord_t r;
		logic [STAGE_W-COORD_W+1:0] top;
		top = v[STAGE_W:COORD_W-1];
		if ((&top) || !(|top)) begin
			r.clip = 1'b0;
			r.val  = v[COORD_W-1:0];
		end else begin
			r.clip = 1'b1;
			r.val  = v[STAGE_W] ? COORD_MIN : COORD_MAX;
		end
		return r;
	endfunction

endpackage
`default_nettype wire

// ----- src/point_rotate_xyz_about_center_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// point_rotate_xyz_about_center_top
// Rotates a Q16.16 point about a center, around X, then Y, then Z.
// ----------------------------------------------------------------------------
// Input channel in_valid/in_ready carries in_x, in_y, in_z; output channel
// out_valid/out_ready carries out_x, out_y, out_z and clipped. A transfer
// happens when valid and ready are both high.
// The config port writes cos/sin of the three angles and the x/y center on
// any cycle with cfg_wr_en high; write it only while no point is in flight.
// From input transfer to output transfer a point passes one stage for the
// center subtraction, two per rotation (product registers, then sum, round
// and saturate), and one for adding the center back and 32-bit saturation.
// Throughput is one point per cycle while the receiver keeps out_ready high,
// set by the four 40x16 multipliers per rotation that are fully pipelined.
// Reset clears all valid bits and loads the identity rotation, center zero.
// When the receiver stalls, items pack up stage by stage; in_ready drops
// only once every stage holds an item, and nothing is lost or repeated.
// ----------------------------------------------------------------------------
module point_rotate_xyz_about_center_top import prxyz_pkg::*; (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire logic signed [COORD_W-1:0]   in_x,
	input  wire logic signed [COORD_W-1:0]   in_y,
	input  wire logic signed [COORD_W-1:0]   in_z,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic signed [COORD_W-1:0]        out_x,
	output logic signed [COORD_W-1:0]        out_y,
	output logic signed [COORD_W-1:0]        out_z,
	output logic                             clipped,
	input  wire logic                        cfg_wr_en,
	input  wire logic [CFG_IDX_W-1:0]        cfg_index,
	input  wire logic [COORD_W-1:0]          cfg_data
);

	cfg_t cfg;

	logic                      v_s1, en_s1;
	logic signed [COORD_W:0]   dx_s1, dy_s1, dz_s1;
	logic signed [STAGE_W-1:0] ex_x, ex_y, ex_z;

	logic                      rx_ready, rx_valid, rx_clip;
	logic signed [STAGE_W-1:0] rx_y, rx_z, rx_x;
	logic                      ry_ready, ry_valid, ry_clip;
	logic signed [STAGE_W-1:0] ry_z, ry_x, ry_y;
	logic                      rz_ready, rz_valid, rz_clip;
	logic signed [STAGE_W-1:0] rz_x, rz_y, rz_z;

	logic                      v_s8, en_s8;
	logic signed [COORD_W-1:0] x_s8, y_s8, z_s8;
	logic                      clip_s8;
	logic signed [STAGE_W:0]   fx, fy, fz;
	sat_coord_t                sx, sy, sz;

	prxyz_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// stage 1: subtract the center
	assign en_s8    = !v_s8 || out_ready;
	assign en_s1    = !v_s1 || rx_ready;
	assign in_ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en_s1) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1 && in_valid) begin
			dx_s1 <= {in_x[COORD_W-1], in_x} - {cfg.pivot_x[COORD_W-1], cfg.pivot_x};
			dy_s1 <= {in_y[COORD_W-1], in_y} - {cfg.pivot_y[COORD_W-1], cfg.pivot_y};
			dz_s1 <= {in_z[COORD_W-1], in_z} - {PIVOT_Z[COORD_W-1], PIVOT_Z};
		end
	end

	assign ex_x = {{(STAGE_W-COORD_W-1){dx_s1[COORD_W]}}, dx_s1};
	assign ex_y = {{(STAGE_W-COORD_W-1){dy_s1[COORD_W]}}, dy_s1};
	assign ex_z = {{(STAGE_W-COORD_W-1){dz_s1[COORD_W]}}, dz_s1};

	// about X: y' = y*ca - z*sa, z' = y*sa + z*ca
	prxyz_rot u_rot_x (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s1),
		.in_ready  (rx_ready),
		.in_a      (ex_y),
		.in_b      (ex_z),
		.in_pass   (ex_x),
		.in_clip   (1'b0),
		.trig_c    (cfg.cos_a),
		.trig_s    (cfg.sin_a),
		.out_valid (rx_valid),
		.out_ready (ry_ready),
		.out_p     (rx_y),
		.out_q     (rx_z),
		.out_pass  (rx_x),
		.out_clip  (rx_clip)
	);

	// about Y: z' = z*cb - x*sb, x' = z*sb + x*cb
	prxyz_rot u_rot_y (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (rx_valid),
		.in_ready  (ry_ready),
		.in_a      (rx_z),
		.in_b      (rx_x),
		.in_pass   (rx_y),
		.in_clip   (rx_clip),
		.trig_c    (cfg.cos_b),
		.trig_s    (cfg.sin_b),
		.out_valid (ry_valid),
		.out_ready (rz_ready),
		.out_p     (ry_z),
		.out_q     (ry_x),
		.out_pass  (ry_y),
		.out_clip  (ry_clip)
	);

	// about Z: x' = x*cg - y*sg, y' = x*sg + y*cg
	prxyz_rot u_rot_z (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (ry_valid),
		.in_ready  (rz_ready),
		.in_a      (ry_x),
		.in_b      (ry_y),
		.in_pass   (ry_z),
		.in_clip   (ry_clip),
		.trig_c    (cfg.cos_g),
		.trig_s    (cfg.sin_g),
		.out_valid (rz_valid),
		.out_ready (en_s8),
		.out_p     (rz_x),
		.out_q     (rz_y),
		.out_pass  (rz_z),
		.out_clip  (rz_clip)
	);

	// add the center back and saturate to 32 bits
	always_comb begin
		fx = {rz_x[STAGE_W-1], rz_x}
		   + {{(STAGE_W-COORD_W+1){cfg.pivot_x[COORD_W-1]}}, cfg.pivot_x};
		fy = {rz_y[STAGE_W-1], rz_y}
		   + {{(STAGE_W-COORD_W+1){cfg.pivot_y[COORD_W-1]}}, cfg.pivot_y};
		fz = {rz_z[STAGE_W-1], rz_z}
		   + {{(STAGE_W-COORD_W+1){PIVOT_Z[COORD_W-1]}}, PIVOT_Z};
		sx = sat_coord(fx);
		sy = sat_coord(fy);
		sz = sat_coord(fz);
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s8 <= 1'b0;
		end else if (en_s8) begin
			v_s8 <= rz_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s8 && rz_valid) begin
			x_s8    <= sx.val;
			y_s8    <= sy.val;
			z_s8    <= sz.val;
			clip_s8 <= rz_clip | sx.clip | sy.clip | sz.clip;
		end
	end

	assign out_valid = v_s8;
	assign out_x     = x_s8;
	assign out_y     = y_s8;
	assign out_z     = z_s8;
	assign clipped   = clip_s8;

	// a ready receiver never back-pressures the input
	a_ready_chain: assert property (@(posedge clk) disable iff (!arst_n)
		out_ready |-> in_ready)
		else $error("ready does not reach the input");

	// input stalls only when the front and the output both hold items
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (v_s1 && out_valid))
		else $error("input stalled with room in the pipeline");

	// stage ranges never overflow, so an unsaturated result is unclipped
	a_clip_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_x != COORD_MAX && out_x != COORD_MIN
			&& out_y != COORD_MAX && out_y != COORD_MIN
			&& out_z != COORD_MAX && out_z != COORD_MIN) |-> !clipped)
		else $error("clipped set without a saturated coordinate");

endmodule
`default_nettype wire

// ----- src/prxyz_cfg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// prxyz_cfg
// Register file for the rotation trig values and the center point.
// ----------------------------------------------------------------------------
module prxyz_cfg import prxyz_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_wr_en,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [COORD_W-1:0]   cfg_data,
	output cfg_t                      cfg
);

	cfg_t regs_q;

	// one register per index, written on enable
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.cos_a   <= 16'sd16384;
			regs_q.sin_a   <= '0;
			regs_q.cos_b   <= 16'sd16384;
			regs_q.sin_b   <= '0;
			regs_q.cos_g   <= 16'sd16384;
			regs_q.sin_g   <= '0;
			regs_q.pivot_x <= '0;
			regs_q.pivot_y <= '0;
		end else if (cfg_wr_en) begin
			case (reg_idx_t'(cfg_index))
				REG_COS_A:   regs_q.cos_a   <= cfg_data[TRIG_W-1:0];
				REG_SIN_A:   regs_q.sin_a   <= cfg_data[TRIG_W-1:0];
				REG_COS_B:   regs_q.cos_b   <= cfg_data[TRIG_W-1:0];
				REG_SIN_B:   regs_q.sin_b   <= cfg_data[TRIG_W-1:0];
				REG_COS_G:   regs_q.cos_g   <= cfg_data[TRIG_W-1:0];
				REG_SIN_G:   regs_q.sin_g   <= cfg_data[TRIG_W-1:0];
				REG_PIVOT_X: regs_q.pivot_x <= cfg_data;
				REG_PIVOT_Y: regs_q.pivot_y <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = regs_q;

endmodule
`default_nettype wire

// ----- src/prxyz_rot.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// prxyz_rot
// One plane rotation in two pipeline stages:
//   p = a*c - b*s,  q = a*s + b*c, each rounded half up and saturated.
// Stage 1 registers the four products, stage 2 sums, rounds and saturates.
// ----------------------------------------------------------------------------
module prxyz_rot import prxyz_pkg::*; (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      in_valid,
	output logic                           in_ready,
	input  wire logic signed [STAGE_W-1:0] in_a,
	input  wire logic signed [STAGE_W-1:0] in_b,
	input  wire logic signed [STAGE_W-1:0] in_pass,
	input  wire logic                      in_clip,
	input  wire logic signed [TRIG_W-1:0]  trig_c,
	input  wire logic signed [TRIG_W-1:0]  trig_s,
	output logic                           out_valid,
	input  wire logic                      out_ready,
	output logic signed [STAGE_W-1:0]      out_p,
	output logic signed [STAGE_W-1:0]      out_q,
	output logic signed [STAGE_W-1:0]      out_pass,
	output logic                           out_clip
);

	logic                      v_s1, v_s2;
	logic                      en_s1, en_s2;
	logic signed [PROD_W-1:0]  ac_s1, bs_s1, as_s1, bc_s1;
	logic signed [STAGE_W-1:0] pass_s1;
	logic                      clip_s1;
	logic signed [STAGE_W-1:0] p_s2, q_s2, pass_s2;
	logic                      clip_s2;
	logic signed [SUM_W-1:0]   sum_p, sum_q, sh_p, sh_q;
	sat_stage_t                sat_p, sat_q;

	// stage advance: a stage moves when empty or when the next one moves
	assign en_s2    = !v_s2 || out_ready;
	assign en_s1    = !v_s1 || en_s2;
	assign in_ready = en_s1;

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (en_s1) begin
				v_s1 <= in_valid;
			end
			if (en_s2) begin
				v_s2 <= v_s1;
			end
		end
	end

	// stage 1: products (signed 40x16)
	always_ff @(posedge clk) begin
		if (en_s1 && in_valid) begin
			ac_s1   <= PROD_W'(in_a) * PROD_W'(trig_c);
			bs_s1   <= PROD_W'(in_b) * PROD_W'(trig_s);
			as_s1   <= PROD_W'(in_a) * PROD_W'(trig_s);
			bc_s1   <= PROD_W'(in_b) * PROD_W'(trig_c);
			pass_s1 <= in_pass;
			clip_s1 <= in_clip;
		end
	end

	// sums, round half up, floor shift, saturate
	always_comb begin
		sum_p = $signed({{(SUM_W-PROD_W){ac_s1[PROD_W-1]}}, ac_s1})
		      - $signed({{(SUM_W-PROD_W){bs_s1[PROD_W-1]}}, bs_s1}) + RND_HALF;
		sum_q = $signed({{(SUM_W-PROD_W){as_s1[PROD_W-1]}}, as_s1})
		      + $signed({{(SUM_W-PROD_W){bc_s1[PROD_W-1]}}, bc_s1}) + RND_HALF;
		sh_p  = sum_p >>> TRIG_FRAC_BITS;
		sh_q  = sum_q >>> TRIG_FRAC_BITS;
		sat_p = sat_stage(sh_p);
		sat_q = sat_stage(sh_q);
	end

	// stage 2: rotated pair
	always_ff @(posedge clk) begin
		if (en_s2 && v_s1) begin
			p_s2    <= sat_p.val;
			q_s2    <= sat_q.val;
			pass_s2 <= pass_s1;
			clip_s2 <= clip_s1 | sat_p.clip | sat_q.clip;
		end
	end

	assign out_valid = v_s2;
	assign out_p     = p_s2;
	assign out_q     = q_s2;
	assign out_pass  = pass_s2;
	assign out_clip  = clip_s2;

	// back-pressure only when both stages hold an item
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (v_s1 && v_s2))
		else $error("rot stalls input with a free stage");

	// a stalled result keeps its value
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && !out_ready) |=> (v_s2 && $stable(p_s2) && $stable(q_s2)))
		else $error("rot stalled result changed");

	// downstream ready always reaches the input
	a_ready_chain: assert property (@(posedge clk) disable iff (!arst_n)
		out_ready |-> in_ready)
		else $error("rot ready chain broken");

endmodule
`default_nettype wire

// ----- dv/tb_point_rotate_xyz_about_center_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_point_rotate_xyz_about_center_top
// Self-checking bench for the 3D point rotator. A behavioral model of the
// X/Y/Z rotation about the center (exact products, round half up, stage and
// 32-bit saturation) predicts every result from a shadow copy of the
// registers. Directed points cover the extremes, quarter and half turns,
// rounding ties and trig values outside [-1, 1]. Random phases then sweep the
// register settings under random idle on both channels, a stretch at full
// rate, and a long output stall that backs the pipeline up into the input.
// ----------------------------------------------------------------------------
module tb_point_rotate_xyz_about_center_top;
	import prxyz_pkg::*;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [TRIG_W-1:0]  trig_t;

	typedef struct packed {
		coord_t x;
		coord_t y;
		coord_t z;
		logic   clip;
	} rot_point_t;

	logic   clk;
	logic   arst_n;
	logic   in_valid;
	logic   in_ready;
	coord_t in_x;
	coord_t in_y;
	coord_t in_z;
	logic   out_valid;
	logic   out_ready;
	coord_t out_x;
	coord_t out_y;
	coord_t out_z;
	logic   clipped;
	logic   cfg_wr_en;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [COORD_W-1:0]   cfg_data;

	// shadow of the register file and the points still in flight
	cfg_t       rot_cfg;
	rot_point_t point_q[$];
	int         mismatches;
	bit         src_gaps;
	bit         sink_gaps;
	int         sink_hold;

	point_rotate_xyz_about_center_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_x      (in_x),
		.in_y      (in_y),
		.in_z      (in_z),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_x     (out_x),
		.out_y     (out_y),
		.out_z     (out_z),
		.clipped   (clipped),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Behavioral model
	// ------------------------------------------------------------------

	// clamp to a signed range of the given width, flag on saturation
	function automatic longint clamp_signed(input longint v, input int bits, inout bit clip);
		longint hi;
		hi = (longint'(1) <<< (bits - 1)) - 1;
		if (v > hi) begin
			clip = 1'b1;
			return hi;
		end
		if (v < -hi - 1) begin
			clip = 1'b1;
			return -hi - 1;
		end
		return v;
	endfunction

	// a*c + b*s, round half up, floor shift, stage saturation
	function automatic longint rot_term(input longint a, c, b, s, inout bit clip);
		longint acc;
		acc = a * c + b * s + (longint'(1) <<< (TRIG_FRAC_BITS - 1));
		return clamp_signed(acc >>> TRIG_FRAC_BITS, STAGE_W, clip);
	endfunction

	function automatic rot_point_t rotated_point(input cfg_t c, input coord_t px, py, pz);
		longint x, y, z, t;
		longint ca, sa, cb, sb, cg, sg, cx, cy, cz;
		bit clip;
		rot_point_t r;
		clip = 1'b0;
		ca = longint'($signed(c.cos_a));
		sa = longint'($signed(c.sin_a));
		cb = longint'($signed(c.cos_b));
		sb = longint'($signed(c.sin_b));
		cg = longint'($signed(c.cos_g));
		sg = longint'($signed(c.sin_g));
		cx = longint'($signed(c.pivot_x));
		cy = longint'($signed(c.pivot_y));
		cz = longint'($signed(PIVOT_Z));
		x = longint'(px) - cx;
		y = longint'(py) - cy;
		z = longint'(pz) - cz;
		// about X
		t = rot_term(y, ca, z, -sa, clip);
		z = rot_term(y, sa, z, ca, clip);
		y = t;
		// about Y
		t = rot_term(x, cb, z, sb, clip);
		z = rot_term(x, -sb, z, cb, clip);
		x = t;
		// about Z
		t = rot_term(x, cg, y, -sg, clip);
		y = rot_term(x, sg, y, cg, clip);
		x = t;
		// back to the center, 32-bit saturation
		r.x = coord_t'(clamp_signed(x + cx, COORD_W, clip));
		r.y = coord_t'(clamp_signed(y + cy, COORD_W, clip));
		r.z = coord_t'(clamp_signed(z + cz, COORD_W, clip));
		r.clip = clip;
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Random values
	// ------------------------------------------------------------------
	function automatic coord_t random_coord();
		logic [COORD_W-1:0] r;
		r = $urandom();
		case ($urandom_range(0, 4))
			0: return coord_t'(r);
			1: return coord_t'($urandom_range(0, 32'h001F_FFFF) - 32'h0010_0000);
			2: return $urandom_range(0, 1) ? COORD_MAX : COORD_MIN;
			3: return rot_cfg.pivot_x + coord_t'($urandom_range(0, 511)) - 256;
			default: return $signed(r) >>> $urandom_range(0, 31);
		endcase
	endfunction

	function automatic trig_t random_trig();
		case ($urandom_range(0, 5))
			0: return trig_t'($urandom());
			1: return $urandom_range(0, 1) ? 16'sd16384 : -16'sd16384;
			2: return '0;
			default: return trig_t'($urandom_range(0, 32768)) - 16'sd16384;
		endcase
	endfunction

	// ------------------------------------------------------------------
	// Register writes (only while nothing is in flight)
	// ------------------------------------------------------------------
	task automatic write_reg(input reg_idx_t idx, input logic [COORD_W-1:0] val);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		case (idx)
			REG_COS_A:   rot_cfg.cos_a   = val[TRIG_W-1:0];
			REG_SIN_A:   rot_cfg.sin_a   = val[TRIG_W-1:0];
			REG_COS_B:   rot_cfg.cos_b   = val[TRIG_W-1:0];
			REG_SIN_B:   rot_cfg.sin_b   = val[TRIG_W-1:0];
			REG_COS_G:   rot_cfg.cos_g   = val[TRIG_W-1:0];
			REG_SIN_G:   rot_cfg.sin_g   = val[TRIG_W-1:0];
			REG_PIVOT_X: rot_cfg.pivot_x = val;
			REG_PIVOT_Y: rot_cfg.pivot_y = val;
			default: ;
		endcase
	endtask

	// load all registers; upper data bits of the trig registers are junk
	task automatic load_rotation(input trig_t ca, sa, cb, sb, cg, sg, input coord_t cx, cy);
		write_reg(REG_COS_A, {16'($urandom()), ca});
		write_reg(REG_SIN_A, {16'($urandom()), sa});
		write_reg(REG_COS_B, {16'($urandom()), cb});
		write_reg(REG_SIN_B, {16'($urandom()), sb});
		write_reg(REG_COS_G, {16'($urandom()), cg});
		write_reg(REG_SIN_G, {16'($urandom()), sg});
		write_reg(REG_PIVOT_X, cx);
		write_reg(REG_PIVOT_Y, cy);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic load_random_rotation();
		load_rotation(random_trig(), random_trig(), random_trig(), random_trig(),
			random_trig(), random_trig(), random_coord(), random_coord());
	endtask

	// ------------------------------------------------------------------
	// Input side: one point per call, entered and left at a rising edge
	// ------------------------------------------------------------------
	task automatic send_point(input coord_t px, py, pz);
		while (src_gaps && $urandom_range(0, 99) < 8) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_x     <= px;
		in_y     <= py;
		in_z     <= pz;
		@(negedge clk);
		while (!in_ready)
			@(negedge clk);
		@(posedge clk);
		point_q.push_back(rotated_point(rot_cfg, px, py, pz));
	endtask

	task automatic send_random_points(input int count);
		repeat (count)
			send_point(random_coord(), random_coord(), random_coord());
	endtask

	// drop valid and hold off until every point has come back
	task automatic end_phase();
		in_valid <= 1'b0;
		while (point_q.size() != 0)
			@(posedge clk);
	endtask

	// ------------------------------------------------------------------
	// Output side: ready with random stalls, plus an on-demand long hold
	// ------------------------------------------------------------------
	initial begin : sink_ready
		forever begin
			@(posedge clk);
			if (sink_hold > 0) begin
				out_ready <= 1'b0;
				sink_hold--;
			end else if (sink_gaps) begin
				out_ready <= ($urandom_range(0, 99) >= 8);
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Compare each output transfer with the oldest prediction
	initial begin : result_check
		rot_point_t got, want;
		forever begin
			@(negedge clk);
			if (arst_n && out_valid && out_ready) begin
				got.x = out_x;
				got.y = out_y;
				got.z = out_z;
				got.clip = clipped;
				if (point_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected transfer: x=%0d y=%0d z=%0d clipped=%0b",
							got.x, got.y, got.z, got.clip);
				end else begin
					want = point_q.pop_front();
					if (got.x !== want.x || got.y !== want.y || got.z !== want.z ||
						got.clip !== want.clip) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch at %0t: exp x=%0d y=%0d z=%0d clipped=%0b, got x=%0d y=%0d z=%0d clipped=%0b",
								$realtime, want.x, want.y, want.z, want.clip,
								got.x, got.y, got.z, got.clip);
					end
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// reset state is the identity about the origin
	task automatic test_reset_identity();
		send_point('0, '0, '0);
		send_point(COORD_MAX, COORD_MAX, COORD_MAX);
		send_point(COORD_MIN, COORD_MIN, COORD_MIN);
		send_point(-32'sd1, 32'sd1, -32'sd1);
		send_point(32'sh0001_0000, -32'sh0002_8000, 32'sh5555_AAAA);
		end_phase();
	endtask

	// quarter and half turns, centers at the range ends, final saturation
	task automatic test_quarter_half_turns();
		load_rotation(16'sd0, 16'sd16384, 16'sd16384, 16'sd0, 16'sd16384, 16'sd0, '0, '0);
		send_point(32'sh0001_0000, 32'sh0002_0000, 32'sh0003_0000);
		send_point(COORD_MIN, COORD_MAX, COORD_MIN);
		end_phase();
		load_rotation(-16'sd16384, 16'sd0, -16'sd16384, 16'sd0, -16'sd16384, 16'sd0,
			COORD_MAX, COORD_MIN);
		send_point(COORD_MIN, COORD_MAX, '0);
		send_point(COORD_MAX, COORD_MIN, COORD_MAX);
		send_point('0, '0, COORD_MIN);
		end_phase();
		load_rotation(16'sd0, -16'sd16384, 16'sd0, -16'sd16384, 16'sd0, -16'sd16384,
			COORD_MIN, COORD_MAX);
		send_point(COORD_MAX, COORD_MIN, COORD_MAX);
		send_point(32'sh1234_5678, -32'sh0765_4321, 32'sh0000_FFFF);
		end_phase();
	endtask

	// half-way sums round up: 0.5 * 1 -> 1, 0.5 * -1 -> 0
	task automatic test_round_half_up();
		load_rotation(16'sd8192, 16'sd0, 16'sd8192, 16'sd0, 16'sd8192, 16'sd0, '0, '0);
		send_point(32'sd1, 32'sd1, 32'sd1);
		send_point(-32'sd1, -32'sd1, -32'sd1);
		send_point(32'sd3, -32'sd3, 32'sd5);
		send_point(32'sd2, -32'sd2, -32'sd6);
		end_phase();
	endtask

	// trig registers outside [-1, 1] are taken as raw 16-bit values
	task automatic test_trig_out_of_range();
		load_rotation(-16'sd32768, 16'sd32767, -16'sd32768, -16'sd32768, 16'sd32767,
			16'sd32767, COORD_MAX, COORD_MIN);
		send_point(COORD_MIN, COORD_MAX, COORD_MIN);
		send_point(COORD_MAX, COORD_MAX, COORD_MAX);
		send_point(32'sd1, -32'sd1, '0);
		end_phase();
		load_rotation(16'sd20000, -16'sd20000, 16'sd32767, 16'sd16385, -16'sd16385,
			-16'sd32767, '0, '0);
		send_point(COORD_MIN, COORD_MIN, COORD_MAX);
		send_point(32'sh0000_8000, 32'sh0003_0000, -32'sh0004_0000);
		end_phase();
	endtask

	// several register settings, extremes first, random idle on both sides
	task automatic test_random_settings();
		load_rotation(16'sd16384, 16'sd16384, 16'sd16384, 16'sd16384, 16'sd16384,
			16'sd16384, COORD_MAX, COORD_MAX);
		send_random_points(80);
		end_phase();
		load_rotation(-16'sd16384, -16'sd16384, -16'sd16384, -16'sd16384, -16'sd16384,
			-16'sd16384, COORD_MIN, COORD_MIN);
		send_random_points(80);
		end_phase();
		repeat (3) begin
			load_random_rotation();
			send_random_points(80);
			end_phase();
		end
	endtask

	// back-to-back transfers with no idle on either side
	task automatic test_full_rate();
		load_random_rotation();
		src_gaps  = 1'b0;
		sink_gaps = 1'b0;
		send_random_points(150);
		end_phase();
		src_gaps  = 1'b1;
		sink_gaps = 1'b1;
	endtask

	// long output stall while input keeps offering: pipeline fills, input stalls
	task automatic test_output_stall();
		load_random_rotation();
		src_gaps = 1'b0;
		@(negedge clk);
		sink_hold = 64;
		@(posedge clk);
		send_random_points(50);
		end_phase();
		src_gaps = 1'b1;
	endtask

	// ------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------
	initial begin
		arst_n     = 1'b0;
		in_valid   = 1'b0;
		in_x       = '0;
		in_y       = '0;
		in_z       = '0;
		out_ready  = 1'b0;
		cfg_wr_en  = 1'b0;
		cfg_index  = REG_COS_A;
		cfg_data   = '0;
		mismatches = 0;
		src_gaps   = 1'b1;
		sink_gaps  = 1'b1;
		sink_hold  = 0;
		rot_cfg.cos_a   = 16'sd16384;
		rot_cfg.sin_a   = '0;
		rot_cfg.cos_b   = 16'sd16384;
		rot_cfg.sin_b   = '0;
		rot_cfg.cos_g   = 16'sd16384;
		rot_cfg.sin_g   = '0;
		rot_cfg.pivot_x = '0;
		rot_cfg.pivot_y = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_identity();
		test_quarter_half_turns();
		test_round_half_up();
		test_trig_out_of_range();
		test_random_settings();
		test_full_rate();
		test_output_stall();

		// let any stray transfer show up before judging
		repeat (20) @(posedge clk);
		if (mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	// watchdog
	initial begin
		#2_000_000;
		$display("simulation failed");
		$finish;
	end

endmodule
